>>> src/delta_list_event_scheduler_macros.svh
// Assertion macros for the delta-list event scheduler.
// Define ASSERT_OFF to compile every check away.
`ifndef DELTA_LIST_EVENT_SCHEDULER_MACROS_SVH
`define DELTA_LIST_EVENT_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define DLES_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("delta list scheduler: invariant violated");
`define DLES_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("delta list scheduler: implication violated");
`define DLES_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("delta list scheduler: next-cycle check violated");
`else
`define DLES_ASSERT(lbl, clk, rst, expr)
`define DLES_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DLES_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/dles_pkg.sv
// Types, constants and microcode ROM for the delta-list event scheduler.
// No dependencies.
package dles_pkg;

   localparam int SLOT_COUNT   = 8;
   localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_FIELD_W = 3;
   localparam int DELAY_W      = 31;
   localparam int AMOUNT_W     = 16;
   localparam int NOW_W        = 32;
   localparam int REM_W        = 32;
   localparam int STAMP_W      = 8;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   localparam logic [1:0] MODE_SCHEDULE = 2'd0;
   localparam logic [1:0] MODE_CANCEL   = 2'd1;
   localparam logic [1:0] MODE_ADVANCE  = 2'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [DELAY_W-1:0]      delay;
      logic [AMOUNT_W-1:0]     amount;
   } req_type;

   typedef struct packed {
      logic                    fired;
      logic [SLOT_FIELD_W-1:0] fired_slot;
      logic [NOW_W-1:0]        now_cycle;
      logic                    last;
   } rsp_type;

   // datapath operation of one microcode step
   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_FETCH,
      UOP_RANK,
      UOP_DROP,
      UOP_ARM,
      UOP_ADVANCE,
      UOP_SCAN_CLR,
      UOP_SCAN,
      UOP_EMIT_ACK,
      UOP_EMIT_FIRE
   } uop_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_ADVANCE,
      JMP_SKIP,
      JMP_CANCEL,
      JMP_NO_DUE,
      JMP_DUE_LEFT
   } jump_type;

   // which slot RANK/DROP/ARM act on
   typedef enum logic {
      TGT_REQ,
      TGT_BEST
   } tgt_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_FETCH     = 4'd0;
   localparam step_type STEP_DECODE    = 4'd1;
   localparam step_type STEP_CHECK     = 4'd2;
   localparam step_type STEP_RANK_REQ  = 4'd3;
   localparam step_type STEP_DROP_REQ  = 4'd4;
   localparam step_type STEP_ARM       = 4'd5;
   localparam step_type STEP_ACK       = 4'd6;
   localparam step_type STEP_ADV       = 4'd7;
   localparam step_type STEP_SCAN_CLR  = 4'd8;
   localparam step_type STEP_SCAN      = 4'd9;
   localparam step_type STEP_RANK_BEST = 4'd10;
   localparam step_type STEP_DROP_BEST = 4'd11;
   localparam step_type STEP_FIRE      = 4'd12;
   localparam step_type STEP_DONE      = 4'd13;

   typedef struct packed {
      uop_type  op;
      tgt_type  tgt;
      jump_type jump;
      step_type dest;
   } uword_type;

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      unique case (step)
         STEP_FETCH:     w = '{UOP_FETCH,     TGT_REQ,  JMP_NEVER,    STEP_FETCH};
         STEP_DECODE:    w = '{UOP_NOP,       TGT_REQ,  JMP_ADVANCE,  STEP_ADV};
         STEP_CHECK:     w = '{UOP_NOP,       TGT_REQ,  JMP_SKIP,     STEP_ACK};
         STEP_RANK_REQ:  w = '{UOP_RANK,      TGT_REQ,  JMP_NEVER,    STEP_FETCH};
         STEP_DROP_REQ:  w = '{UOP_DROP,      TGT_REQ,  JMP_CANCEL,   STEP_ACK};
         STEP_ARM:       w = '{UOP_ARM,       TGT_REQ,  JMP_NEVER,    STEP_FETCH};
         STEP_ACK:       w = '{UOP_EMIT_ACK,  TGT_REQ,  JMP_ALWAYS,   STEP_FETCH};
         STEP_ADV:       w = '{UOP_ADVANCE,   TGT_REQ,  JMP_NEVER,    STEP_FETCH};
         STEP_SCAN_CLR:  w = '{UOP_SCAN_CLR,  TGT_BEST, JMP_NO_DUE,   STEP_ACK};
         STEP_SCAN:      w = '{UOP_SCAN,      TGT_BEST, JMP_NEVER,    STEP_FETCH};
         STEP_RANK_BEST: w = '{UOP_RANK,      TGT_BEST, JMP_NEVER,    STEP_FETCH};
         STEP_DROP_BEST: w = '{UOP_DROP,      TGT_BEST, JMP_NEVER,    STEP_FETCH};
         STEP_FIRE:      w = '{UOP_EMIT_FIRE, TGT_BEST, JMP_DUE_LEFT, STEP_SCAN_CLR};
         STEP_DONE:      w = '{UOP_NOP,       TGT_REQ,  JMP_ALWAYS,   STEP_FETCH};
         default:        w = '{UOP_NOP,       TGT_REQ,  JMP_ALWAYS,   STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

>>> src/delta_list_event_scheduler.sv
// Delta-list event scheduler: microcoded sequencer over a bank of slot registers.
// Depends on dles_pkg and delta_list_event_scheduler_macros.svh.
//
//   port group  dir  width / type      role
//   req_*       in   req_type          schedule / cancel / advance beats
//   rsp_*       out  rsp_type          ack or fired-slot beats, last marks end
//
// Schedule runs fetch, decode, check, rank, drop, arm, ack; cancel ends at drop, then ack;
// advance with nothing due runs fetch, decode, advance, scan clear, ack. Each fired slot costs
// a one-slot-per-cycle scan for the earliest due slot, then rank, drop and fire.
// Reset is synchronous and clears control state; no clearing pass is needed.
// rsp_stall holds only the emit steps; a new req beat is taken while a result waits.
`include "delta_list_event_scheduler_macros.svh"

module delta_list_event_scheduler
   import dles_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam slot_idx_type LAST_IDX = slot_idx_type'(SLOT_COUNT - 1);

   step_type              pc_ff, pc_in;
   req_type               req_ff, req_in;
   logic [SLOT_COUNT-1:0] armed_ff, armed_in;
   logic [SLOT_COUNT-1:0] due_ff, due_in;
   logic [REM_W-1:0]      rem_ff   [SLOT_COUNT];
   logic [REM_W-1:0]      rem_in   [SLOT_COUNT];
   logic [STAMP_W-1:0]    stamp_ff [SLOT_COUNT];
   logic [STAMP_W-1:0]    stamp_in [SLOT_COUNT];
   logic [STAMP_W-1:0]    order_ff, order_in;
   logic [NOW_W-1:0]      elapsed_ff, elapsed_in;
   logic [STAMP_W-1:0]    rank_ff, rank_in;
   logic                  hit_ff, hit_in;
   slot_idx_type          scan_ff, scan_in;
   slot_idx_type          best_ff, best_in;
   logic [REM_W-1:0]      best_rem_ff, best_rem_in;
   logic [STAMP_W-1:0]    best_stamp_ff, best_stamp_in;
   logic                  best_vld_ff, best_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   uword_type          uw;
   slot_idx_type       tgt_idx;
   slot_idx_type       rd_idx;
   logic [REM_W-1:0]   rd_rem;
   logic [STAMP_W-1:0] rd_stamp;
   logic               rd_armed;
   logic               rsp_block;
   logic               slot_ok;
   logic               step_done;
   logic               jump_taken;

   assign uw        = ucode_rom(pc_ff);
   assign tgt_idx   = (uw.tgt == TGT_BEST) ? best_ff : slot_idx_type'(req_ff.slot);
   // read index shared by rem, stamp and armed: the scan pointer or the current target
   assign rd_idx    = (uw.op == UOP_SCAN) ? scan_ff : tgt_idx;
   assign rd_rem    = rem_ff[rd_idx];
   assign rd_stamp  = stamp_ff[rd_idx];
   assign rd_armed  = armed_ff[rd_idx];
   assign rsp_block = rsp_valid_ff && rsp_stall;
   assign slot_ok   = int'(req_ff.slot) < SLOT_COUNT;

   assign req_stall = (uw.op != UOP_FETCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer: step completion, branch condition, next step
   always_comb begin
      unique case (uw.op)
         UOP_FETCH:     step_done = req_valid;
         UOP_SCAN:      step_done = (scan_ff == LAST_IDX);
         UOP_EMIT_ACK,
         UOP_EMIT_FIRE: step_done = !rsp_block;
         default:       step_done = 1'b1;
      endcase

      unique case (uw.jump)
         JMP_NEVER:    jump_taken = 1'b0;
         JMP_ALWAYS:   jump_taken = 1'b1;
         JMP_ADVANCE:  jump_taken = (req_ff.mode == MODE_ADVANCE);
         JMP_SKIP:     jump_taken = !((req_ff.mode == MODE_SCHEDULE) ||
                                      (req_ff.mode == MODE_CANCEL)) || !slot_ok;
         JMP_CANCEL:   jump_taken = (req_ff.mode == MODE_CANCEL);
         JMP_NO_DUE:   jump_taken = (due_ff == '0);
         JMP_DUE_LEFT: jump_taken = (due_ff != '0);
         default:      jump_taken = 1'b0;
      endcase

      if (!step_done) begin
         pc_in = pc_ff;
      end else if (jump_taken) begin
         pc_in = uw.dest;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   // datapath driven by the control word
   always_comb begin
      logic [REM_W-1:0] amt;

      amt           = REM_W'(req_ff.amount);
      req_in        = req_ff;
      armed_in      = armed_ff;
      due_in        = due_ff;
      rem_in        = rem_ff;
      stamp_in      = stamp_ff;
      order_in      = order_ff;
      elapsed_in    = elapsed_ff;
      rank_in       = rank_ff;
      hit_in        = hit_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_rem_in   = best_rem_ff;
      best_stamp_in = best_stamp_ff;
      best_vld_in   = best_vld_ff;
      rsp_valid_in  = rsp_block;
      rsp_in        = rsp_ff;

      unique case (uw.op)
         UOP_FETCH: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         UOP_RANK: begin
            rank_in = rd_stamp;
            hit_in  = rd_armed;
            if (uw.tgt == TGT_BEST) begin
               due_in[tgt_idx] = 1'b0;
            end
         end
         UOP_DROP: begin
            // keep ranks dense: later-armed slots move up one
            if (hit_ff) begin
               armed_in[tgt_idx] = 1'b0;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (armed_ff[i] && (stamp_ff[i] > rank_ff)) begin
                     stamp_in[i] = stamp_ff[i] - 8'd1;
                  end
               end
               order_in = order_ff - 8'd1;
            end
         end
         UOP_ARM: begin
            armed_in[tgt_idx] = 1'b1;
            rem_in[tgt_idx]   = REM_W'(req_ff.delay);
            stamp_in[tgt_idx] = order_ff;
            order_in          = order_ff + 8'd1;
         end
         UOP_ADVANCE: begin
            elapsed_in = elapsed_ff + NOW_W'(req_ff.amount);
            for (int i = 0; i < SLOT_COUNT; i++) begin
               due_in[i] = armed_ff[i] && (rem_ff[i] <= amt);
               if (armed_ff[i] && (rem_ff[i] > amt)) begin
                  rem_in[i] = rem_ff[i] - amt;
               end
            end
         end
         UOP_SCAN_CLR: begin
            scan_in     = '0;
            best_vld_in = 1'b0;
         end
         UOP_SCAN: begin
            if (due_ff[scan_ff] &&
                (!best_vld_ff || (rd_rem < best_rem_ff) ||
                 ((rd_rem == best_rem_ff) && (rd_stamp < best_stamp_ff)))) begin
               best_in       = scan_ff;
               best_rem_in   = rd_rem;
               best_stamp_in = rd_stamp;
               best_vld_in   = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
         end
         UOP_EMIT_ACK: begin
            if (!rsp_block) begin
               rsp_valid_in      = 1'b1;
               rsp_in.fired      = 1'b0;
               rsp_in.fired_slot = '0;
               rsp_in.now_cycle  = elapsed_ff;
               rsp_in.last       = 1'b1;
            end
         end
         UOP_EMIT_FIRE: begin
            if (!rsp_block) begin
               rsp_valid_in      = 1'b1;
               rsp_in.fired      = 1'b1;
               rsp_in.fired_slot = SLOT_FIELD_W'(best_ff);
               rsp_in.now_cycle  = elapsed_ff;
               rsp_in.last       = (due_ff == '0);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_FETCH;
         armed_ff     <= '0;
         due_ff       <= '0;
         order_ff     <= '0;
         elapsed_ff   <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         armed_ff     <= armed_in;
         due_ff       <= due_in;
         order_ff     <= order_in;
         elapsed_ff   <= elapsed_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rem_ff        <= rem_in;
      stamp_ff      <= stamp_in;
      rank_ff       <= rank_in;
      hit_ff        <= hit_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_rem_ff   <= best_rem_in;
      best_stamp_ff <= best_stamp_in;
      rsp_ff        <= rsp_in;
   end

   `DLES_ASSERT(a_order_count, clock, reset, order_ff == STAMP_W'($countones(armed_ff)))
   `DLES_ASSERT(a_due_armed, clock, reset, (due_ff & ~armed_ff) == '0)
   `DLES_ASSERT_NXT(a_scan_finds, clock, reset, (uw.op == UOP_SCAN) && step_done, best_vld_ff)

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_rank_chk
      `DLES_ASSERT_IMP(a_stamp_dense, clock, reset, armed_ff[g], stamp_ff[g] < order_ff)
   end

endmodule
